// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the key debounce / display scanner.
// Users must have clk and rst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define KDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define KDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/kds_pkg.sv
// Package for the key debounce / display scanner: field widths, pipeline types,
// and the seven-segment numeral table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kds_pkg;

  localparam int KEY_FIELD_W  = 5;   // raw key level field
  localparam int DIGIT_FIELDS = 4;   // digit code fields per transaction
  localparam int CODE_W       = 4;
  localparam int SEG_W        = 8;
  localparam int EN_W         = 4;
  localparam int KEYNUM_W     = 3;
  localparam int BLINK_W      = 3;
  localparam int HIST_W       = 4;
  localparam int PHASE_W      = 2;
  localparam int BCNT_W       = 4;

  localparam logic [HIST_W-1:0] HIST_RELEASED = 4'hF;
  localparam logic [HIST_W-1:0] HIST_PRESSED  = 4'h0;
  localparam logic [CODE_W-1:0] DASH_CODE     = 4'd10;
  localparam logic [BLINK_W-1:0] BLINK_RESET  = 3'd5;

  typedef logic [DIGIT_FIELDS-1:0][CODE_W-1:0] digit_codes_t;

  typedef struct packed {
    logic [KEY_FIELD_W-1:0] key_levels;
    digit_codes_t           digits;
  } in_item_t;

  typedef struct packed {
    logic [SEG_W-1:0]    segments;
    logic [EN_W-1:0]     digit_enables;
    logic [KEYNUM_W-1:0] key_pressed;
  } out_item_t;

  // Numeral table, codes 0-9 plus dash; callers clamp the code first
  function automatic logic [SEG_W-1:0] seg_lookup(input logic [CODE_W-1:0] code);
    logic [SEG_W-1:0] seg;
    case (code)
      4'd0:    seg = 8'h3f;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5b;
      4'd3:    seg = 8'h4f;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6d;
      4'd6:    seg = 8'h7d;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7f;
      4'd9:    seg = 8'h6f;
      default: seg = 8'h40;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

// File: hdl/key_debounce_display_scanner_top.sv
// Top level: input register, debounce and display scanner, result register.
// Depends on kds_pkg, kds_debounce, kds_scanner and assert_macros.svh.
//
// Usage: each input transaction is one timer tick carrying five raw key
// levels (0 = pressed) and four digit codes. Every input transaction yields
// exactly one result transaction: the held segment pattern, the held one-hot
// or blank digit enable and the number of a newly pressed key (0 if none).
// out_valid rises once the tick has passed the input register and then the
// result register. Throughput is one transaction per cycle while out_stall
// does not hold a result; the single pass of debounce and scan logic between
// the two registers sets that.
// cfg_we/cfg_wdata write the blink digit index (4 and up disables blinking);
// write only while no transaction is in flight.
// Reset (rst_n low, synchronous) empties both stages, sets all keys released,
// clears the scan state and sets the blink index to 5.
// When out_stall holds a pending result, the input register can still fill
// once; after that in_stall rises until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module key_debounce_display_scanner_top #(
  parameter int NUM_KEYS   = 5,
  parameter int NUM_DIGITS = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [kds_pkg::BLINK_W-1:0]      cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [kds_pkg::KEY_FIELD_W-1:0]  in_key_levels,
  input  wire logic [kds_pkg::CODE_W-1:0]       in_digit_zero,
  input  wire logic [kds_pkg::CODE_W-1:0]       in_digit_one,
  input  wire logic [kds_pkg::CODE_W-1:0]       in_digit_two,
  input  wire logic [kds_pkg::CODE_W-1:0]       in_digit_three,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [kds_pkg::SEG_W-1:0]        out_segments,
  output logic      [kds_pkg::EN_W-1:0]         out_digit_enables,
  output logic      [kds_pkg::KEYNUM_W-1:0]     out_key_pressed
);

  logic [kds_pkg::BLINK_W-1:0] blink_digit_r;
  logic                        s1_valid_r;
  kds_pkg::in_item_t           s1_item_r;
  logic                        out_valid_r;
  kds_pkg::out_item_t          out_item_r, out_item_nxt;
  logic                        out_ready;
  logic                        advance;
  logic                        in_take;

  assign out_ready = !out_valid_r || !out_stall;
  assign advance   = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_digit_r <= kds_pkg::BLINK_RESET;
    end else if (cfg_we) begin
      blink_digit_r <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.key_levels <= in_key_levels;
      s1_item_r.digits     <= {in_digit_three, in_digit_two, in_digit_one, in_digit_zero};
    end
  end

  kds_debounce #(
    .NUM_KEYS (NUM_KEYS)
  ) u_debounce (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .key_levels  (s1_item_r.key_levels),
    .key_pressed (out_item_nxt.key_pressed)
  );

  kds_scanner #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_scanner (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .blink_digit (blink_digit_r),
    .digits      (s1_item_r.digits),
    .seg_next    (out_item_nxt.segments),
    .en_next     (out_item_nxt.digit_enables)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_segments      = out_item_r.segments;
  assign out_digit_enables = out_item_r.digit_enables;
  assign out_key_pressed   = out_item_r.key_pressed;

  `KDS_ASSERT_NOW(a_en_onehot, out_valid, $onehot0(out_digit_enables), "digit enable not one-hot")
  `KDS_ASSERT_NEXT(a_s1_hold, s1_valid_r && !out_ready, s1_valid_r, "stalled tick dropped")
  `KDS_ASSERT_NOW(a_key_range, out_valid, int'(out_key_pressed) <= NUM_KEYS, "key number out of range")

endmodule

`default_nettype wire

// File: hdl/kds_debounce.sv
// Per-key four-sample debounce and press-edge detect for the key scanner.
// Depends on kds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kds_debounce #(
  parameter int NUM_KEYS = 5
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           step,
  input  wire logic [kds_pkg::KEY_FIELD_W-1:0] key_levels,
  output logic      [kds_pkg::KEYNUM_W-1:0]   key_pressed
);

  localparam int KNUM_W = $clog2(NUM_KEYS + 1);
  localparam int PAD_W  = (NUM_KEYS > kds_pkg::KEY_FIELD_W) ? NUM_KEYS : kds_pkg::KEY_FIELD_W;

  logic [NUM_KEYS-1:0][kds_pkg::HIST_W-1:0] hist_r, hist_nxt;
  logic [NUM_KEYS-1:0]                      level_r, level_nxt;
  logic [NUM_KEYS-1:0]                      prev_r;
  logic [PAD_W-1:0]                         lv_pad;
  logic [KNUM_W-1:0]                        pressed;

  always_comb begin
    // keys past the input field read as released
    lv_pad = '1;
    lv_pad[kds_pkg::KEY_FIELD_W-1:0] = key_levels;
    pressed = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      hist_nxt[i]  = {hist_r[i][kds_pkg::HIST_W-2:0], lv_pad[i]};
      level_nxt[i] = level_r[i];
      if (hist_nxt[i] == kds_pkg::HIST_PRESSED) begin
        level_nxt[i] = 1'b0;
      end else if (hist_nxt[i] == kds_pkg::HIST_RELEASED) begin
        level_nxt[i] = 1'b1;
      end
      // ascending scan: highest falling key wins
      if (prev_r[i] && !level_nxt[i]) begin
        pressed = KNUM_W'(i + 1);
      end
    end
  end

  assign key_pressed = kds_pkg::KEYNUM_W'(pressed);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        hist_r[i] <= kds_pkg::HIST_RELEASED;
      end
      level_r <= '1;
      prev_r  <= '1;
    end else if (step) begin
      hist_r  <= hist_nxt;
      level_r <= level_nxt;
      prev_r  <= level_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/kds_scanner.sv
// Multiplexed seven-segment digit scanner with one blinking digit.
// Depends on kds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kds_scanner #(
  parameter int NUM_DIGITS = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step,
  input  wire logic [kds_pkg::BLINK_W-1:0]  blink_digit,
  input  wire kds_pkg::digit_codes_t        digits,
  output logic      [kds_pkg::SEG_W-1:0]    seg_next,
  output logic      [kds_pkg::EN_W-1:0]     en_next
);

  localparam int PTR_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  logic [kds_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [PTR_W-1:0]            ptr_r, ptr_nxt;
  logic [kds_pkg::BCNT_W-1:0]  bcnt_r, bcnt_nxt;
  logic                        blink_on_r, blink_on_nxt;
  logic [kds_pkg::SEG_W-1:0]   seg_r, seg_nxt;
  logic [kds_pkg::EN_W-1:0]    en_r, en_nxt;
  logic [kds_pkg::CODE_W-1:0]  code;
  logic [kds_pkg::SEG_W-1:0]   seg_show;
  logic [kds_pkg::EN_W-1:0]    en_show;

  always_comb begin
    // digits beyond the input fields show code 0
    code = '0;
    for (int d = 0; d < kds_pkg::DIGIT_FIELDS; d++) begin
      if (int'(ptr_r) == d) begin
        code = digits[d];
      end
    end
    if (code > kds_pkg::DASH_CODE) begin
      code = kds_pkg::DASH_CODE;
    end
    seg_show = kds_pkg::seg_lookup(code);
    for (int e = 0; e < kds_pkg::EN_W; e++) begin
      en_show[e] = (int'(ptr_r) == e);
    end
  end

  always_comb begin
    phase_nxt    = phase_r + kds_pkg::PHASE_W'(1);
    ptr_nxt      = ptr_r;
    bcnt_nxt     = bcnt_r;
    blink_on_nxt = blink_on_r;
    seg_nxt      = seg_r;
    en_nxt       = en_r;
    if (phase_nxt == '0) begin
      if (int'(ptr_r) == int'(blink_digit)) begin
        bcnt_nxt = bcnt_r + kds_pkg::BCNT_W'(1);
        if (bcnt_nxt == '0) begin
          blink_on_nxt = !blink_on_r;
        end
        if (blink_on_nxt) begin
          seg_nxt = seg_show;
          en_nxt  = en_show;
        end else begin
          en_nxt = '0;  // blanked; segments keep last pattern
        end
      end else begin
        seg_nxt = seg_show;
        en_nxt  = en_show;
      end
      if (int'(ptr_r) >= NUM_DIGITS - 1) begin
        ptr_nxt = '0;
      end else begin
        ptr_nxt = ptr_r + PTR_W'(1);
      end
    end
  end

  assign seg_next = seg_nxt;
  assign en_next  = en_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= '0;
      ptr_r      <= '0;
      bcnt_r     <= '0;
      blink_on_r <= 1'b0;
      seg_r      <= '0;
      en_r       <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      ptr_r      <= ptr_nxt;
      bcnt_r     <= bcnt_nxt;
      blink_on_r <= blink_on_nxt;
      seg_r      <= seg_nxt;
      en_r       <= en_nxt;
    end
  end

endmodule

`default_nettype wire

// File: verif/key_debounce_display_scanner_top_tb.sv
// Self-checking testbench for key_debounce_display_scanner_top: random and
// directed ticks, a scan/debounce predictor and an in-order result check.
// Depends on kds_pkg and the top level RTL.
`timescale 1ns / 1ps

module key_debounce_display_scanner_top_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 4;   // two register stages plus slack

  localparam logic [kds_pkg::SEG_W-1:0] SEG_PATTERN [0:10] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f, 8'h40
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [kds_pkg::BLINK_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [kds_pkg::KEY_FIELD_W-1:0] in_key_levels = '1;
  logic [kds_pkg::CODE_W-1:0] in_digit_zero = '0;
  logic [kds_pkg::CODE_W-1:0] in_digit_one = '0;
  logic [kds_pkg::CODE_W-1:0] in_digit_two = '0;
  logic [kds_pkg::CODE_W-1:0] in_digit_three = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [kds_pkg::SEG_W-1:0] out_segments;
  logic [kds_pkg::EN_W-1:0] out_digit_enables;
  logic [kds_pkg::KEYNUM_W-1:0] out_key_pressed;

  key_debounce_display_scanner_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_key_levels    (in_key_levels),
    .in_digit_zero    (in_digit_zero),
    .in_digit_one     (in_digit_one),
    .in_digit_two     (in_digit_two),
    .in_digit_three   (in_digit_three),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_segments     (out_segments),
    .out_digit_enables(out_digit_enables),
    .out_key_pressed  (out_key_pressed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state
  logic [kds_pkg::BLINK_W-1:0] blink_sel;
  logic [kds_pkg::HIST_W-1:0]  key_hist [kds_pkg::KEY_FIELD_W];
  logic                        key_db [kds_pkg::KEY_FIELD_W];
  logic                        key_last [kds_pkg::KEY_FIELD_W];
  logic [kds_pkg::PHASE_W-1:0] phase;
  logic [1:0]                  scan_ptr;
  logic [kds_pkg::BCNT_W-1:0]  visit_cnt;
  logic                        blink_lit;
  logic [kds_pkg::SEG_W-1:0]   held_seg;
  logic [kds_pkg::EN_W-1:0]    held_en;

  kds_pkg::in_item_t  ticks_pending [$];
  kds_pkg::out_item_t scan_results_due [$];

  int errors = 0;
  int cycles = 0;
  logic in_taken = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  int hold_req = 0;
  int hold_served = 0;
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  kds_pkg::in_item_t drive_item;
  logic stall_next;

  // Stimulus generator state: the level each key is being held at
  logic [kds_pkg::KEY_FIELD_W-1:0] key_target = '1;
  int run_left = 0;

  function automatic int pick_gap(input bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic void show(input kds_pkg::in_item_t it, input logic [1:0] ptr);
    logic [kds_pkg::CODE_W-1:0] code;
    code = it.digits[ptr];
    if (code > kds_pkg::DASH_CODE) code = kds_pkg::DASH_CODE;
    held_seg = SEG_PATTERN[code];
    held_en  = kds_pkg::EN_W'(1) << ptr;
  endfunction

  function automatic kds_pkg::out_item_t scan_tick(input kds_pkg::in_item_t it);
    kds_pkg::out_item_t r;
    logic [kds_pkg::KEYNUM_W-1:0] pressed;
    pressed = '0;
    for (int i = 0; i < kds_pkg::KEY_FIELD_W; i++) begin
      key_hist[i] = {key_hist[i][kds_pkg::HIST_W-2:0], it.key_levels[i]};
      if (key_hist[i] == kds_pkg::HIST_PRESSED) key_db[i] = 1'b0;
      else if (key_hist[i] == kds_pkg::HIST_RELEASED) key_db[i] = 1'b1;
    end
    // highest falling key wins
    for (int i = 0; i < kds_pkg::KEY_FIELD_W; i++) begin
      if (key_last[i] && !key_db[i]) pressed = kds_pkg::KEYNUM_W'(i + 1);
      key_last[i] = key_db[i];
    end
    phase = phase + 1'b1;
    if (phase == '0) begin
      if ({1'b0, scan_ptr} == blink_sel) begin
        visit_cnt = visit_cnt + 1'b1;
        if (visit_cnt == '0) blink_lit = !blink_lit;
        if (blink_lit) show(it, scan_ptr);
        else held_en = '0;
      end else begin
        show(it, scan_ptr);
      end
      scan_ptr = scan_ptr + 1'b1;
    end
    r.segments      = held_seg;
    r.digit_enables = held_en;
    r.key_pressed   = pressed;
    return r;
  endfunction

  // Monitor: predictor update on input transactions, check on results
  always @(posedge clk) begin
    kds_pkg::out_item_t due;
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else if (!rst_n) begin
      blink_sel = kds_pkg::BLINK_RESET;
      for (int i = 0; i < kds_pkg::KEY_FIELD_W; i++) begin
        key_hist[i] = kds_pkg::HIST_RELEASED;
        key_db[i]   = 1'b1;
        key_last[i] = 1'b1;
      end
      phase     = '0;
      scan_ptr  = '0;
      visit_cnt = '0;
      blink_lit = 1'b0;
      held_seg  = '0;
      held_en   = '0;
      in_taken <= 1'b0;
    end else begin
      if (cfg_we) blink_sel = cfg_wdata;
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall)
        scan_results_due.push_back(scan_tick('{in_key_levels,
          {in_digit_three, in_digit_two, in_digit_one, in_digit_zero}}));
      if (out_valid && !out_stall) begin
        if (scan_results_due.size() == 0) begin
          $display("%0t: unexpected result seg %h en %h key %0d", $realtime,
                   out_segments, out_digit_enables, out_key_pressed);
          errors++;
        end else begin
          due = scan_results_due.pop_front();
          if (out_segments !== due.segments) begin
            $display("%0t: segments expected %h got %h", $realtime,
                     due.segments, out_segments);
            errors++;
          end
          if (out_digit_enables !== due.digit_enables) begin
            $display("%0t: digit_enables expected %h got %h", $realtime,
                     due.digit_enables, out_digit_enables);
            errors++;
          end
          if (out_key_pressed !== due.key_pressed) begin
            $display("%0t: key_pressed expected %0d got %0d", $realtime,
                     due.key_pressed, out_key_pressed);
            errors++;
          end
        end
      end
    end
  end

  // Driver: holds a stalled transaction, else draws the next tick after a gap
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // payload stays put
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap--;
    end else if (ticks_pending.size() > 0) begin
      drive_item = ticks_pending.pop_front();
      in_key_levels  <= drive_item.key_levels;
      in_digit_zero  <= drive_item.digits[0];
      in_digit_one   <= drive_item.digits[1];
      in_digit_two   <= drive_item.digits[2];
      in_digit_three <= drive_item.digits[3];
      in_valid <= 1'b1;
      send_gap = pick_gap(send_idle);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver stall, including the long hold-off on request
  always @(negedge clk) begin
    if (hold_served != hold_req) begin
      hold_served++;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      stall_next = 1'b1;
    end else begin
      stall_left = pick_gap(recv_idle);
      stall_next = (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
    out_stall <= stall_next;
  end

  task automatic push_tick(input logic [kds_pkg::KEY_FIELD_W-1:0] lv,
                           input logic [kds_pkg::CODE_W-1:0] d0,
                           input logic [kds_pkg::CODE_W-1:0] d1,
                           input logic [kds_pkg::CODE_W-1:0] d2,
                           input logic [kds_pkg::CODE_W-1:0] d3);
    kds_pkg::in_item_t it;
    it.key_levels = lv;
    it.digits = {d3, d2, d1, d0};
    ticks_pending.push_back(it);
  endtask

  function automatic logic [kds_pkg::CODE_W-1:0] rand_code();
    if ($urandom_range(0, 99) < 80) return kds_pkg::CODE_W'($urandom_range(0, 10));
    return kds_pkg::CODE_W'($urandom_range(11, 15));
  endfunction

  // Mostly keys held steady long enough to debounce, with bounce noise
  task automatic push_random(input int n);
    logic [kds_pkg::KEY_FIELD_W-1:0] lv;
    int r;
    for (int k = 0; k < n; k++) begin
      if (run_left == 0) begin
        if ($urandom_range(0, 3) == 0)
          key_target = kds_pkg::KEY_FIELD_W'($urandom_range(0, 31));
        else
          key_target ^= kds_pkg::KEY_FIELD_W'(1) <<
                        $urandom_range(0, kds_pkg::KEY_FIELD_W - 1);
        run_left = $urandom_range(2, 14);
      end
      run_left--;
      r = $urandom_range(0, 99);
      lv = key_target;
      if (r < 5) lv = kds_pkg::KEY_FIELD_W'($urandom_range(0, 31));
      else if (r < 15)
        lv ^= kds_pkg::KEY_FIELD_W'(1) << $urandom_range(0, kds_pkg::KEY_FIELD_W - 1);
      push_tick(lv, rand_code(), rand_code(), rand_code(), rand_code());
    end
  endtask

  task automatic wait_drained();
    while (ticks_pending.size() != 0 || in_valid || scan_results_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_blink(input logic [kds_pkg::BLINK_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [kds_pkg::BLINK_W-1:0] settings [7];
    settings = '{3'd3, 3'd7, 3'd1, 3'd4, 3'd2, 3'd6, 3'd0};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // blink on digit 0 starts blanked, since the blink phase resets off
    write_blink(3'd0);
    // all keys fall together; codes above ten show a dash
    repeat (4) push_tick(5'h00, 4'd0, 4'd10, 4'd11, 4'd15);
    repeat (4) push_tick(5'h1f, 4'd15, 4'd14, 4'd9, 4'd1);
    // single key press and release
    repeat (4) push_tick(5'h1e, 4'd2, 4'd3, 4'd4, 4'd5);
    repeat (4) push_tick(5'h1f, 4'd6, 4'd7, 4'd8, 4'd12);
    // bounce never settles
    push_tick(5'h15, 4'd13, 4'd0, 4'd1, 4'd2);
    push_tick(5'h0a, 4'd3, 4'd13, 4'd4, 4'd5);
    push_tick(5'h15, 4'd6, 4'd7, 4'd13, 4'd8);
    push_tick(5'h0a, 4'd9, 4'd10, 4'd11, 4'd13);
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      send_idle = (p != 3);
      recv_idle = (p != 3);
      write_blink(settings[p]);
      push_random(190);
      // receiver holds off while the sender keeps offering transactions
      if (p == 1 || p == 5) hold_req++;
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
